### sv/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared types and codes for the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SLOT_W = 6;

  // operation codes
  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_TRAV   = 2'd2,
    OP_SEARCH = 2'd3
  } cqs_kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } cqs_status_t;

  typedef struct packed {
    cqs_kind_t                 kind;
    logic signed [DATA_W-1:0]  value;
  } cqs_in_t;

  typedef struct packed {
    cqs_status_t               status;
    logic signed [DATA_W-1:0]  data;
    logic [SLOT_W-1:0]         slot;
    logic                      last;
  } cqs_out_t;

endpackage

### sv/cqs_mem.sv
// ----------------------------------------------------------------------------
// cqs_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqs_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [cqs_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic signed [cqs_pkg::DATA_W-1:0] rdata
);
  import cqs_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/circular_queue_with_search.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search
// Ring-buffer FIFO of signed 32-bit values with traverse and key search.
// ----------------------------------------------------------------------------
// enqueue and every request that hits a full or empty queue:
//   result strobed the cycle after the request, busy stays low
// dequeue: one slot read through the synchronous memory port, result registered from S_DEQ
// traverse and search: one slot read per cycle
// results cannot be stalled; out_valid pulses for one cycle per result
// synchronous active-low reset empties the queue; slot contents are kept
module circular_queue_with_search #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cqs_pkg::cqs_in_t  in_req,
  output logic              out_valid,
  output cqs_pkg::cqs_out_t out_res
);
  import cqs_pkg::*;

  // pointer and count widths follow the depth
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_TRAV,
    S_SRCH
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [PTR_W-1:0]         tail_r, tail_nxt;
  logic [CNT_W-1:0]         occ_r, occ_nxt;
  logic [PTR_W-1:0]         scan_p_r, scan_p_nxt;   // slot whose data arrives now
  logic [CNT_W-1:0]         scan_i_r, scan_i_nxt;   // entries already visited
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  cqs_out_t                 out_res_r, out_res_nxt;

  // memory port signals
  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic [PTR_W-1:0]         mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  logic                     accept;
  logic                     scan_last;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  // last occupied entry of a scan is being looked at
  assign scan_last = (CNT_W'(scan_i_r + 1'b1) == occ_r);

  cqs_mem #(
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_req.value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    scan_p_nxt    = scan_p_r;
    scan_i_nxt    = scan_i_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_res_nxt = '{status: ST_OK, data: '0, slot: '0, last: 1'b1};
          if (in_req.kind == OP_ENQ) begin
            out_valid_nxt = 1'b1;
            if (occ_r == CNT_FULL) begin
              out_res_nxt.status = ST_FULL;
            end else begin
              // write at the tail, report the slot written
              mem_we           = 1'b1;
              tail_nxt         = wrap_inc(tail_r);
              occ_nxt          = occ_r + 1'b1;
              out_res_nxt.slot = SLOT_W'(tail_r);
            end
          end else if (occ_r == '0) begin
            // dequeue, traverse and search on an empty queue
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = ST_EMPTY;
          end else begin
            // head slot read is issued now, data comes next cycle
            scan_p_nxt = head_r;
            scan_i_nxt = '0;
            key_nxt    = in_req.value;
            case (in_req.kind)
              OP_DEQ: begin
                head_nxt  = wrap_inc(head_r);
                occ_nxt   = occ_r - 1'b1;
                state_nxt = S_DEQ;
              end
              OP_TRAV:   state_nxt = S_TRAV;
              OP_SEARCH: state_nxt = S_SRCH;
              default:   state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_DEQ: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = '{status: ST_OK, data: mem_rdata, slot: '0, last: 1'b1};
        state_nxt     = S_IDLE;
      end

      S_TRAV: begin
        // one stored entry per cycle, next read issued in parallel
        mem_raddr     = wrap_inc(scan_p_r);
        scan_p_nxt    = wrap_inc(scan_p_r);
        scan_i_nxt    = scan_i_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_res_nxt   = '{status: ST_OK, data: mem_rdata, slot: '0, last: scan_last};
        if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end

      S_SRCH: begin
        mem_raddr  = wrap_inc(scan_p_r);
        scan_p_nxt = wrap_inc(scan_p_r);
        scan_i_nxt = scan_i_r + 1'b1;
        if (mem_rdata == key_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: ST_OK, data: '0, slot: SLOT_W'(scan_p_r), last: 1'b1};
          state_nxt     = S_IDLE;
        end else if (scan_last) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{status: ST_NOTFOUND, data: '0, slot: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      scan_i_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      scan_i_r    <= scan_i_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_p_r  <= scan_p_nxt;
    key_r     <= key_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // occupancy never exceeds the ring size
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_FULL)
    else $error("occupancy beyond depth");

  // an empty queue has matching pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> head_r == tail_r)
    else $error("pointers differ on empty queue");

  // a successful enqueue grows the queue by one
  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.kind == OP_ENQ && occ_r != CNT_FULL |=> occ_r == $past(occ_r) + 1'b1)
    else $error("enqueue did not grow occupancy");

  // the dequeue read stage always produces its result
  a_deq_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEQ |=> out_valid && out_res.last)
    else $error("dequeue result missing");

  // scans never run past the stored entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRAV || state_r == S_SRCH) |-> scan_i_r < occ_r)
    else $error("scan beyond occupancy");

endmodule
